@@ design/servo_command_slew_controller_assert.svh @@
`ifndef SERVO_COMMAND_SLEW_CONTROLLER_ASSERT_SVH
`define SERVO_COMMAND_SLEW_CONTROLLER_ASSERT_SVH
// assertion helpers
`define SCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/scs_pkg.sv @@
package scs_pkg;
  localparam int LINE_BUFFER = 24;
  localparam int LineMax = LINE_BUFFER - 1;
  localparam int CntW = $clog2(LINE_BUFFER);
  localparam int IdxW = $clog2(LineMax);

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       axis;
    logic [7:0] servo_angle;
    logic [7:0] report_pan;
    logic [7:0] report_tilt;
  } out_t;

  typedef struct packed {
    logic [9:0] step_delay;
    logic [9:0] idle_timeout;
    logic [7:0] center_deg;
    logic [7:0] floor_deg;
    logic [7:0] ceil_deg;
  } cfg_t;

  localparam logic [2:0] EvWrite = 3'd0;
  localparam logic [2:0] EvPos = 3'd1;
  localparam logic [2:0] EvHelp = 3'd2;
  localparam logic [2:0] EvInvalid = 3'd3;
  localparam logic [2:0] EvTooLong = 3'd4;
  localparam logic [2:0] EvBusy = 3'd5;

  localparam logic [2:0] RegStep = 3'd0;
  localparam logic [2:0] RegIdle = 3'd1;
  localparam logic [2:0] RegCenter = 3'd2;
  localparam logic [2:0] RegMin = 3'd3;
  localparam logic [2:0] RegMax = 3'd4;

  function automatic logic [7:0] clamp_angle(input logic signed [10:0] v,
                                             input logic [7:0] lo,
                                             input logic [7:0] hi);
    logic [7:0] r;
    if (v < $signed({3'b0, lo})) r = lo;
    else if (v > $signed({3'b0, hi})) r = hi;
    else r = v[7:0];
    return r;
  endfunction
endpackage

@@ design/servo_command_slew_controller.sv @@
// channel | dir | payload
// in      | in  | in_t  kind, rx_byte
// out     | out | out_t event_res, axis, servo_angle, report_pan, report_tilt
// cfg     | in  | index, data
// a tick or stored byte waits in the queue and is then handled by the back end
// a line run walks the line store, one ram read per character,
// paced by the single read port
// a two-entry queue takes requests while the back end is busy or stalled, until both entries are full
// reset restores the control registers at once, no clearing pass; queue entries and line store are not reset
module servo_command_slew_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  scs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output scs_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [9:0]    cfg_data_i
);
  import scs_pkg::*;
  cfg_t cfg_q;
  logic qv, qr;
  in_t qd;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{10'd15, 10'd80, 8'd90, 8'd0, 8'd180};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegStep: cfg_q.step_delay <= cfg_data_i;
        RegIdle: cfg_q.idle_timeout <= cfg_data_i;
        RegCenter: cfg_q.center_deg <= cfg_data_i[7:0];
        RegMin: cfg_q.floor_deg <= cfg_data_i[7:0];
        RegMax: cfg_q.ceil_deg <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end
  scs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_data_o(qd)
  );
  scs_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(qv), .q_ready_o(qr), .q_data_i(qd),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule

@@ design/scs_ram.sv @@
module scs_ram #(
  parameter int Width = 8,
  parameter int Depth = 23
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/scs_front.sv @@
module scs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  scs_pkg::in_t  in_data_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output scs_pkg::in_t  q_data_o
);
  import scs_pkg::*;
  in_t  ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic rd_q, wr_q;
  logic push, pop;
  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = ent_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= in_data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end
endmodule

@@ design/scs_back.sv @@
module scs_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  scs_pkg::cfg_t cfg_i,
  input  logic         q_valid_i,
  output logic         q_ready_o,
  input  scs_pkg::in_t q_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output scs_pkg::out_t out_data_o
);
  import scs_pkg::*;
  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SScan = 4'd1;
  localparam logic [3:0] SDecide = 4'd3;
  localparam logic [3:0] SPre = 4'd4;
  localparam logic [3:0] SPval = 4'd5;
  localparam logic [3:0] SPcomma = 4'd6;
  localparam logic [3:0] SOut = 4'd7;

  logic [3:0] st_q;
  logic [CntW-1:0] cnt_q, len_q, ptr_q, end_q, comma_q;
  logic [9:0] quiet_q, timer_q;
  logic [7:0] pan_q, tilt_q, rangle_q, rtarget_q, ptarget_q, c0_q;
  logic moving_q, raxis_q, tpend_q, found_q, second_q;
  logic [1:0] phase_q;
  logic neg_q;
  logic [9:0] mag_q;
  out_t res_q;
  logic ovalid_q;

  logic we, rwait_q;
  logic [IdxW-1:0] raddr;
  logic [7:0] rdata;

  scs_ram #(.Width(8), .Depth(LineMax)) u_ram (
    .clk_i, .we_i(we), .waddr_i(cnt_q[IdxW-1:0]), .wdata_i(q_data_i.rx_byte),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign raddr = ptr_q[IdxW-1:0];
  assign q_ready_o = (st_q == SIdle) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o = res_q;
  logic take;
  assign take = q_valid_i && q_ready_o;
  assign we = take && !q_data_i.kind && !moving_q && q_data_i.rx_byte != 8'h0a &&
              q_data_i.rx_byte != 8'h0d && cnt_q < CntW'(LineMax);

  logic [7:0] center_c;
  assign center_c = clamp_angle({3'b0, cfg_i.center_deg}, cfg_i.floor_deg,
                                cfg_i.ceil_deg);
  logic signed [10:0] pval;
  assign pval = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  logic [9:0] tnext;
  assign tnext = timer_q + 10'd1;
  logic [13:0] mag10;
  assign mag10 = {4'b0, mag_q} * 14'd10 + {10'b0, rdata[3:0]};

  function automatic out_t ev(input logic [2:0] e);
    out_t o;
    o = '0;
    o.event_res = e;
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; quiet_q <= '0; timer_q <= '0;
      pan_q <= 8'd90; tilt_q <= 8'd90; rangle_q <= '0; rtarget_q <= '0;
      ptarget_q <= '0; moving_q <= 1'b0; raxis_q <= 1'b0; tpend_q <= 1'b0;
      ovalid_q <= 1'b0; res_q <= '0; len_q <= '0; ptr_q <= '0; end_q <= '0;
      comma_q <= '0; c0_q <= '0; found_q <= 1'b0; second_q <= 1'b0;
      phase_q <= '0; neg_q <= 1'b0; mag_q <= '0; rwait_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (st_q)
        SIdle: if (take) begin
          if (q_data_i.kind) begin
            if (moving_q) begin
              if (tnext >= cfg_i.step_delay) begin
                timer_q <= '0;
                ovalid_q <= 1'b1;
                if (rangle_q == rtarget_q) begin
                  if (raxis_q) tilt_q <= rtarget_q; else pan_q <= rtarget_q;
                  if (!raxis_q && tpend_q) begin
                    tpend_q <= 1'b0; raxis_q <= 1'b1; rangle_q <= tilt_q;
                    rtarget_q <= ptarget_q;
                    res_q <= '{EvWrite, 1'b1, tilt_q, 8'd0, 8'd0};
                  end else begin
                    moving_q <= 1'b0;
                    res_q <= '{EvPos, 1'b0, 8'd0, raxis_q ? pan_q : rtarget_q,
                               raxis_q ? rtarget_q : tilt_q};
                  end
                end else begin
                  rangle_q <= (rtarget_q > rangle_q) ? rangle_q + 8'd1 : rangle_q - 8'd1;
                  res_q <= '{EvWrite, raxis_q,
                             (rtarget_q > rangle_q) ? rangle_q + 8'd1 : rangle_q - 8'd1,
                             8'd0, 8'd0};
                end
              end else timer_q <= tnext;
            end else if (cnt_q != '0) begin
              if (quiet_q != 10'd1023) quiet_q <= quiet_q + 10'd1;
              if (((quiet_q == 10'd1023) ? quiet_q : quiet_q + 10'd1) >= cfg_i.idle_timeout)
              begin
                len_q <= cnt_q; ptr_q <= '0; found_q <= 1'b0; rwait_q <= 1'b1;
                end_q <= cnt_q; st_q <= SScan;
              end
            end
          end else if (moving_q) begin
            res_q <= ev(EvBusy); ovalid_q <= 1'b1;
          end else if (q_data_i.rx_byte == 8'h0a || q_data_i.rx_byte == 8'h0d) begin
            if (cnt_q != '0) begin
              len_q <= cnt_q; ptr_q <= '0; found_q <= 1'b0; rwait_q <= 1'b1;
              end_q <= cnt_q; st_q <= SScan;
            end
          end else if (cnt_q < CntW'(LineMax)) begin
            cnt_q <= cnt_q + 1'b1; quiet_q <= '0;
          end else begin
            cnt_q <= '0; res_q <= ev(EvTooLong); ovalid_q <= 1'b1;
          end
        end
        // walk line: find length (zero byte) and first comma
        SScan: begin
          if (rwait_q) rwait_q <= 1'b0;
          else begin
            if (ptr_q == '0) c0_q <= rdata;
            if (rdata == 8'h00) begin
              end_q <= ptr_q; st_q <= SDecide;
            end else begin
              if (rdata == 8'h2c && !found_q) begin found_q <= 1'b1; comma_q <= ptr_q; end
              if (ptr_q + 1'b1 == len_q) begin
                end_q <= len_q; st_q <= SDecide;
              end else begin
                ptr_q <= ptr_q + 1'b1; rwait_q <= 1'b1;
              end
            end
          end
        end
        SDecide: begin
          cnt_q <= '0; quiet_q <= '0; tpend_q <= 1'b0;
          if (end_q == '0) c0_q <= 8'h00;
          if (end_q == '0) begin
            res_q <= ev(EvInvalid); st_q <= SOut;
          end else if (c0_q == 8'h3f || c0_q == 8'h68 || c0_q == 8'h48) begin
            res_q <= ev(EvHelp); st_q <= SOut;
          end else if (c0_q == 8'h63 || c0_q == 8'h43) begin
            ptarget_q <= center_c; tpend_q <= 1'b1;
            raxis_q <= 1'b0; rangle_q <= pan_q; rtarget_q <= center_c;
            timer_q <= '0; moving_q <= 1'b1;
            res_q <= '{EvWrite, 1'b0, pan_q, 8'd0, 8'd0}; st_q <= SOut;
          end else if (c0_q == 8'h70 || c0_q == 8'h50 || c0_q == 8'h74 || c0_q == 8'h54)
          begin
            second_q <= (c0_q == 8'h74 || c0_q == 8'h54);
            found_q <= 1'b0; ptr_q <= CntW'(1); st_q <= SPre;
          end else if (found_q) begin
            ptr_q <= comma_q + 1'b1; second_q <= 1'b1; st_q <= SPcomma;
          end else begin
            res_q <= ev(EvInvalid); st_q <= SOut;
          end
          phase_q <= '0; neg_q <= 1'b0; mag_q <= '0; rwait_q <= 1'b1;
        end
        // value parser, one char per read; phase 0 spaces, 2 sign or digits seen
        SPre, SPcomma, SPval: begin
          if (rwait_q) rwait_q <= 1'b0;
          else begin
            logic stop;
            stop = (ptr_q >= end_q);
            if (!stop) begin
              if (phase_q == 2'd0 && (rdata == 8'h20 || (rdata >= 8'd9 && rdata <= 8'd13)))
                ;
              else if (phase_q == 2'd0 && (rdata == 8'h2b || rdata == 8'h2d)) begin
                neg_q <= (rdata == 8'h2d); phase_q <= 2'd2;
              end else if (rdata >= 8'h30 && rdata <= 8'h39) begin
                phase_q <= 2'd2;
                mag_q <= (mag10 > 14'd999) ? 10'd999 : mag10[9:0];
              end else stop = 1'b1;
            end
            if (!stop) begin ptr_q <= ptr_q + 1'b1; rwait_q <= 1'b1; end
            else begin
              phase_q <= '0; neg_q <= 1'b0; mag_q <= '0;
              if (st_q == SPre) begin
                raxis_q <= second_q;
                rangle_q <= second_q ? tilt_q : pan_q;
                rtarget_q <= clamp_angle(pval, cfg_i.floor_deg, cfg_i.ceil_deg);
                timer_q <= '0; moving_q <= 1'b1;
                res_q <= '{EvWrite, second_q, second_q ? tilt_q : pan_q, 8'd0, 8'd0};
                st_q <= SOut;
              end else if (st_q == SPcomma) begin
                ptarget_q <= clamp_angle(pval, cfg_i.floor_deg, cfg_i.ceil_deg);
                tpend_q <= 1'b1; end_q <= comma_q; ptr_q <= '0; rwait_q <= 1'b1;
                second_q <= 1'b0; st_q <= SPre;
              end else st_q <= SOut;
            end
          end
        end
        SOut: begin
          ovalid_q <= 1'b1; st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

@@ design/scs_checker.sv @@
`include "servo_command_slew_controller_assert.svh"
module scs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input scs_pkg::out_t out_data_i
);
  import scs_pkg::*;
  `SCS_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))
  `SCS_ASSERT_IMPL(a_range, out_valid_i, out_data_i.event_res <= EvBusy)
  `SCS_ASSERT_IMPL(a_angle, out_valid_i && out_data_i.event_res == EvWrite,
                   out_data_i.report_pan == 8'd0 && out_data_i.report_tilt == 8'd0)
endmodule

bind servo_command_slew_controller scs_checker u_chk (
  .clk_i, .rst_ni, .out_valid_i(out_valid_o), .out_ready_i,
  .out_data_i(out_data_o)
);

@@ tb/servo_command_slew_controller_tb.sv @@
`timescale 1ns / 1ps

module servo_command_slew_controller_tb;
  import scs_pkg::*;

  localparam int StoreMax = 23;
  localparam int QuietLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [9:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  servo_command_slew_controller dut (.*);

  // predictor state
  logic [9:0] p_step, p_idle;
  logic [7:0] p_center, p_min, p_max;
  logic [7:0] p_line [StoreMax];
  int p_count, p_quiet;
  logic [7:0] p_pan, p_tilt, p_angle, p_target, p_pend_target;
  logic p_moving, p_axis, p_pend;
  int p_timer;

  in_t request_q[$];
  out_t event_q[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  int hold_off = 0;
  int pending_reqs = 0;

  function automatic logic [7:0] bound(int v);
    if (v < int'(p_min)) return p_min;
    if (v > int'(p_max)) return p_max;
    return v[7:0];
  endfunction

  function automatic int read_value(int from, int upto);
    int i;
    bit neg;
    int mag;
    i = from;
    neg = 1'b0;
    mag = 0;
    while (i < upto && (p_line[i] == 8'd32 || (p_line[i] >= 8'd9 && p_line[i] <= 8'd13))) i++;
    if (i < upto && (p_line[i] == "+" || p_line[i] == "-")) begin
      neg = p_line[i] == "-";
      i++;
    end
    while (i < upto && p_line[i] >= "0" && p_line[i] <= "9") begin
      mag = mag * 10 + int'(p_line[i] - "0");
      if (mag > 999) mag = 999;
      i++;
    end
    return neg ? -mag : mag;
  endfunction

  function automatic out_t mk_event(logic [2:0] ev, logic ax, logic [7:0] ang,
                                    logic [7:0] rp, logic [7:0] rt);
    out_t o;
    o.event_res = ev;
    o.axis = ax;
    o.servo_angle = ang;
    o.report_pan = rp;
    o.report_tilt = rt;
    return o;
  endfunction

  function automatic out_t begin_slew(logic ax, logic [7:0] tgt);
    p_axis = ax;
    p_angle = ax ? p_tilt : p_pan;
    p_target = tgt;
    p_timer = 0;
    p_moving = 1'b1;
    return mk_event(EvWrite, p_axis, p_angle, '0, '0);
  endfunction

  function automatic out_t run_line();
    int n;
    logic [7:0] c0;
    n = 0;
    while (n < p_count && p_line[n] != 8'd0) n++;
    c0 = n > 0 ? p_line[0] : 8'd0;
    p_count = 0;
    p_quiet = 0;
    p_pend = 1'b0;
    if (c0 == "?" || c0 == "h" || c0 == "H") return mk_event(EvHelp, 1'b0, '0, '0, '0);
    if (c0 == "c" || c0 == "C") begin
      p_pend_target = bound(p_center);
      p_pend = 1'b1;
      return begin_slew(1'b0, bound(p_center));
    end
    if (c0 == "p" || c0 == "P") return begin_slew(1'b0, bound(read_value(1, n)));
    if (c0 == "t" || c0 == "T") return begin_slew(1'b1, bound(read_value(1, n)));
    for (int i = 0; i < n; i++) begin
      if (p_line[i] == ",") begin
        p_pend_target = bound(read_value(i + 1, n));
        p_pend = 1'b1;
        return begin_slew(1'b0, bound(read_value(0, i)));
      end
    end
    return mk_event(EvInvalid, 1'b0, '0, '0, '0);
  endfunction

  function automatic void predict_event(in_t r);
    if (r.kind) begin
      if (p_moving) begin
        p_timer = (p_timer + 1) & 10'h3ff;
        if (p_timer < int'(p_step)) return;
        p_timer = 0;
        if (p_angle == p_target) begin
          if (p_axis) p_tilt = p_target;
          else p_pan = p_target;
          if (!p_axis && p_pend) begin
            p_pend = 1'b0;
            event_q.push_back(begin_slew(1'b1, p_pend_target));
            return;
          end
          p_moving = 1'b0;
          event_q.push_back(mk_event(EvPos, 1'b0, '0, p_pan, p_tilt));
          return;
        end
        if (p_target > p_angle) p_angle++;
        else p_angle--;
        event_q.push_back(mk_event(EvWrite, p_axis, p_angle, '0, '0));
        return;
      end
      if (p_count == 0) return;
      if (p_quiet < 1023) p_quiet++;
      if (p_quiet >= int'(p_idle)) event_q.push_back(run_line());
      return;
    end
    if (p_moving) begin
      event_q.push_back(mk_event(EvBusy, 1'b0, '0, '0, '0));
      return;
    end
    if (r.rx_byte == 8'd10 || r.rx_byte == 8'd13) begin
      if (p_count != 0) event_q.push_back(run_line());
      return;
    end
    if (p_count < StoreMax) begin
      p_line[p_count] = r.rx_byte;
      p_count++;
      p_quiet = 0;
      return;
    end
    p_count = 0;
    event_q.push_back(mk_event(EvTooLong, 1'b0, '0, '0, '0));
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_event(in_data_i);
      pending_reqs--;
    end
    if (!in_valid_i || in_ready_o) begin
      if (request_q.size() > 0 && (no_idle || $urandom_range(99) >= 6)) begin
        in_valid_i <= 1'b1;
        in_data_i <= request_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (event_q.size() == 0) begin
        $display("%0t unexpected event expected none actual %h", $time, out_data_o);
        errors++;
      end else begin
        out_t e;
        e = event_q.pop_front();
        if (e.event_res != out_data_o.event_res || e.axis != out_data_o.axis ||
            e.servo_angle != out_data_o.servo_angle ||
            e.report_pan != out_data_o.report_pan ||
            e.report_tilt != out_data_o.report_tilt) begin
          $display("%0t event mismatch expected %h actual %h", $time, e, out_data_o);
          errors++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || $urandom_range(99) >= 6;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegStep: p_step = val;
      RegIdle: p_idle = val;
      RegCenter: p_center = val[7:0];
      RegMin: p_min = val[7:0];
      RegMax: p_max = val[7:0];
      default: ;
    endcase
  endtask

  task automatic push_byte(logic [7:0] b);
    in_t r;
    r.kind = 1'b0;
    r.rx_byte = b;
    request_q.push_back(r);
    pending_reqs++;
  endtask

  task automatic push_ticks(int n);
    in_t r;
    r.kind = 1'b1;
    r.rx_byte = 8'($urandom);
    repeat (n) begin
      request_q.push_back(r);
      pending_reqs++;
      r.rx_byte = 8'($urandom);
    end
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic drain();
    int lim;
    lim = 0;
    while ((pending_reqs > 0 || event_q.size() > 0) && lim < 2000000) begin
      @(posedge clk_i);
      lim++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  function automatic string rand_value();
    string s;
    s = "";
    repeat ($urandom_range(2)) s = {s, " "};
    case ($urandom_range(3))
      0: s = {s, "-"};
      1: s = {s, "+"};
      default: ;
    endcase
    repeat ($urandom_range(1, 4)) s = {s, string'(8'("0" + $urandom_range(9)))};
    return s;
  endfunction

  task automatic rand_command();
    string s;
    case ($urandom_range(9))
      0: s = "c";
      1: s = {"p", rand_value()};
      2: s = {"T", rand_value()};
      3, 4: s = {rand_value(), ",", rand_value()};
      5: s = "h";
      6: s = "x1";
      7: begin
        s = "";
        repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom))};
      end
      default: s = {"P", string'(8'($urandom_range(48, 57)))};
    endcase
    push_text(s);
    if ($urandom_range(3) != 0) push_byte($urandom_range(1) ? 8'd13 : 8'd10);
    else push_ticks(int'(p_idle) + 1);
    push_ticks(3);
    if ($urandom_range(5) == 0) push_byte(8'($urandom));
    push_ticks(8);
  endtask

  initial begin
    p_step = 10'd15; p_idle = 10'd80; p_center = 8'd90; p_min = 8'd0; p_max = 8'd180;
    p_count = 0; p_quiet = 0; p_pan = 8'd90; p_tilt = 8'd90;
    p_moving = 1'b0; p_axis = 1'b0; p_angle = '0; p_target = '0; p_timer = 0;
    p_pend = 1'b0; p_pend_target = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed
    write_reg(RegStep, 10'd1);
    write_reg(RegIdle, 10'd3);
    push_text("?\r");
    push_text("c\n");
    push_ticks(4);
    push_text("p 999\r");
    push_ticks(100);
    push_text("a");
    push_ticks(10);
    push_text("t-9999,\n");
    push_ticks(100);
    push_text(" +170 , -3\r");
    push_ticks(20);
    push_text("zz\n\n\r");
    for (int i = 0; i < 24; i++) push_byte(8'($urandom_range(48, 57)));
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h0d);
    push_byte(8'hff);
    push_byte(8'h0a);
    push_ticks(10);
    drain();

    write_reg(RegCenter, 10'd180);
    write_reg(RegMin, 10'd100);
    write_reg(RegMax, 10'd20);
    write_reg(RegStep, 10'd0);
    write_reg(RegIdle, 10'd40);
    push_text("C\r");
    push_ticks(180);
    push_text("7");
    push_ticks(42);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(RegStep, ph == 4 ? 10'($urandom_range(20, 40)) : 10'($urandom_range(0, 3)));
      write_reg(RegIdle, 10'($urandom_range(0, 6)));
      write_reg(RegCenter, 10'($urandom_range(0, 180)));
      write_reg(RegMin, ph == 0 ? 10'd0 : 10'($urandom_range(0, 60)));
      write_reg(RegMax, ph == 0 ? 10'd180 : 10'($urandom_range(100, 180)));
      no_idle = ph == 2;
      if (ph == 1) hold_off = 3000;
      if (ph == 4) begin
        push_text("p1\r");
        push_ticks(60);
      end else begin
        for (int k = 0; k < 3; k++) rand_command();
      end
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
